@@ rtl/swa_pkg.sv @@
// Shared constants, command and status types for the sliding window average core.
package swa_pkg;

    // Delay line depth; must be a power of two so the pointer wraps by truncation.
    localparam int MAX_WINDOW  = 256;
    localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 24;
    // The fill count briefly reaches MAX_WINDOW + 1 before the oldest sample drops out.
    localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 2);
    localparam int WIN_BITS    = 9;
    localparam int OUT_BITS    = 17;
    localparam int OUT_LIMIT   = 65535;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int STEP_BITS   = $clog2(DIV_STEPS + 1);

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = WIN_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_MODE   = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic update;
        logic div_init;
        logic div_step;
        logic finish;
        logic emit;
    } t_swa_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_swa_status;

endpackage

@@ rtl/sliding_window_average_core.sv @@
// Top level of the sliding window average core: controller, datapath and delay line RAM.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_sample, i_record_start
//   output    out        o_valid / i_stall   o_filtered
//   config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// Each item passes from acceptance to the next acceptance, when the output is free, through
// one delay line read, one update, 24 steps of the bit-serial divider and three control steps.
// The divider gives one quotient bit per cycle; a new item waits until the last one is done.
// Reset is synchronous and active low; the delay line needs no clearing pass.
// A result waits in the output register while the next item is accepted; a stall at the
// output adds cycles only when a new result finds the register still full.
module sliding_window_average_core
    import swa_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_record_start,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_BITS-1:0]    o_filtered,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    t_swa_cmd               cmd;
    t_swa_status            status;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // Sequencer.
    swa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Arithmetic and output register.
    swa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample       (i_sample),
        .i_record_start (i_record_start),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_filtered     (o_filtered)
    );

    // Delay line of past samples.
    swa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

@@ rtl/swa_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/swa_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
module swa_ctrl
    import swa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_swa_status i_status,
    output logic        o_stall,
    output t_swa_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.update = 1'b1;
                n_state      = S_INIT;
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ rtl/swa_datapath.sv @@
// Datapath: running sum, fill count, bit-serial divider, result and output register.
module swa_datapath
    import swa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_swa_cmd                 i_cmd,
    output t_swa_status              o_status,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                     i_record_start,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_ram_we,
    output logic [ADDR_BITS-1:0]     o_ram_waddr,
    output logic [SAMPLE_BITS-1:0]   o_ram_wdata,
    output logic [ADDR_BITS-1:0]     o_ram_raddr,
    input  logic [SAMPLE_BITS-1:0]   i_ram_rdata,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic signed [OUT_BITS-1:0] o_filtered
);

    localparam int AVG_BITS = SUM_BITS + 1;
    localparam int RES_BITS = SUM_BITS + 2;

    logic [WIN_BITS-1:0]    r_window;
    logic                   r_mode;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [SUM_BITS-1:0]    r_sum;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic                   r_drop;
    logic [ADDR_BITS-1:0]   r_wp;
    logic [COUNT_BITS-1:0]  r_rem;
    logic [SUM_BITS-1:0]    r_quo;
    logic                   r_neg;
    logic [STEP_BITS-1:0]   r_step;
    logic [OUT_BITS-1:0]    r_res;
    logic [OUT_BITS-1:0]    r_out;
    logic                   r_out_valid;

    logic [COUNT_BITS-1:0]  w_eff;
    logic [SUM_BITS-1:0]    sum_base;
    logic [SUM_BITS-1:0]    sum_add;
    logic [COUNT_BITS-1:0]  cnt_base;
    logic [COUNT_BITS-1:0]  cnt_add;
    logic [SUM_BITS-1:0]    x_ext;
    logic [SUM_BITS-1:0]    old_ext;
    logic [SUM_BITS-1:0]    sum_mag;
    logic [COUNT_BITS:0]    partial;
    logic [COUNT_BITS+1:0]  trial;
    logic                   quo_bit;
    logic signed [AVG_BITS-1:0] avg;
    logic signed [RES_BITS-1:0] res_full;
    logic signed [RES_BITS-1:0] x_wide;
    logic [OUT_BITS-1:0]    res_sat;

    // Effective window: zero counts as one, large values clamp to the depth.
    always_comb begin
        if (r_window == '0) begin
            w_eff = COUNT_BITS'(1);
        end else if (COUNT_BITS'(r_window) > COUNT_BITS'(MAX_WINDOW)) begin
            w_eff = COUNT_BITS'(MAX_WINDOW);
        end else begin
            w_eff = COUNT_BITS'(r_window);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_BITS'(1);
            r_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_window <= i_cfg_data;
                CFG_FILTER_MODE:   r_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Add the new sample; a record start discards the old sum and count.
    assign x_ext    = {{(SUM_BITS-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
    assign sum_base = i_record_start ? '0 : r_sum;
    assign cnt_base = i_record_start ? '0 : r_cnt;
    assign sum_add  = sum_base + x_ext;
    assign cnt_add  = cnt_base + COUNT_BITS'(1);
    assign old_ext  = {{(SUM_BITS-SAMPLE_BITS){i_ram_rdata[SAMPLE_BITS-1]}}, i_ram_rdata};

    // Delay line access: read the sample one window back, then overwrite the slot.
    assign o_ram_raddr = r_wp - w_eff[ADDR_BITS-1:0];
    assign o_ram_we    = i_cmd.update;
    assign o_ram_waddr = r_wp;
    assign o_ram_wdata = r_x;

    // Sum, count and write pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_wp  <= '0;
        end else if (i_cmd.load) begin
            r_sum <= sum_add;
            r_cnt <= cnt_add;
        end else if (i_cmd.update) begin
            if (r_drop) begin
                r_sum <= r_sum - old_ext;
                r_cnt <= r_cnt - COUNT_BITS'(1);
            end
            r_wp <= r_wp + ADDR_BITS'(1);
        end
    end

    // Item payload held for the whole computation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample;
            r_drop <= (cnt_add > w_eff);
        end
    end

    // Restoring division of the sum magnitude by the fill count, one bit a step.
    assign sum_mag = r_sum[SUM_BITS-1] ? (~r_sum + SUM_BITS'(1)) : r_sum;
    assign partial = {r_rem, r_quo[SUM_BITS-1]};
    assign trial   = {1'b0, partial} - {2'b00, r_cnt};
    assign quo_bit = ~trial[COUNT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.div_init) begin
            r_step <= STEP_BITS'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_step <= r_step - STEP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= sum_mag;
            r_neg <= r_sum[SUM_BITS-1];
        end else if (i_cmd.div_step) begin
            r_rem <= quo_bit ? trial[COUNT_BITS-1:0] : partial[COUNT_BITS-1:0];
            r_quo <= {r_quo[SUM_BITS-2:0], quo_bit};
        end
    end

    // Signed average, optional high-pass difference and saturation.
    assign avg      = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign x_wide   = RES_BITS'($signed(r_x));
    assign res_full = r_mode ? (x_wide - RES_BITS'(avg)) : RES_BITS'(avg);

    always_comb begin
        if (res_full > RES_BITS'(OUT_LIMIT)) begin
            res_sat = OUT_BITS'(OUT_LIMIT);
        end else if (res_full < -RES_BITS'(OUT_LIMIT)) begin
            res_sat = OUT_BITS'(-OUT_LIMIT);
        end else begin
            res_sat = res_full[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res <= res_sat;
        end
    end

    // Output register, independent of the input side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_status.div_last = (r_step == STEP_BITS'(1));
    assign o_status.out_free = ~r_out_valid | ~i_stall;
    assign o_valid           = r_out_valid;
    assign o_filtered        = $signed(r_out);

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window average core: directed table, random phases.
module tb_top
    import swa_pkg::*;
();

    localparam int NUM_RANDOM_ITEMS = 1550;
    localparam int IDLE_LIMIT       = 2000;
    localparam int LONG_HOLD        = 300;
    localparam int END_CYCLES       = 64;

    localparam logic signed [SAMPLE_BITS-1:0] MAX_SAMPLE = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] MIN_SAMPLE = 16'sh8000;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_style;

    // One row of directed stimulus: either a register setting or one item.
    typedef struct packed {
        t_row_kind                     kind;
        logic [CFG_DATA_BITS-1:0]      win;
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          start;
        logic                          typed;
        logic signed [OUT_BITS-1:0]    want;
    } t_stim_row;

    localparam int NUM_ROWS = 30;

    // Directed rows: defaults after reset, mode 1, window zero and oversized window,
    // truncation toward zero, then windows toggled inside one record until the output clamps.
    localparam t_stim_row DIR_ROWS [NUM_ROWS] = '{
        '{ROW_ITEM, 9'd0,   1'b0, MAX_SAMPLE, 1'b0, 1'b1, 17'sd32767},
        '{ROW_ITEM, 9'd0,   1'b0, MIN_SAMPLE, 1'b0, 1'b1, -17'sd32768},
        '{ROW_ITEM, 9'd0,   1'b0, 16'sd0,     1'b1, 1'b1, 17'sd0},
        '{ROW_CFG,  9'd1,   1'b1, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MIN_SAMPLE, 1'b0, 1'b1, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MAX_SAMPLE, 1'b1, 1'b1, 17'sd0},
        '{ROW_CFG,  9'd0,   1'b0, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, 16'sd12345, 1'b1, 1'b1, 17'sd12345},
        '{ROW_ITEM, 9'd0,   1'b0, -16'sd1,    1'b0, 1'b1, -17'sd1},
        '{ROW_CFG,  9'd511, 1'b0, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MAX_SAMPLE, 1'b1, 1'b1, 17'sd32767},
        '{ROW_ITEM, 9'd0,   1'b0, MIN_SAMPLE, 1'b0, 1'b1, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, -16'sd3,    1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  9'd256, 1'b1, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, -16'sd5,    1'b1, 1'b1, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, 16'sd2,     1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  9'd2,   1'b0, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MIN_SAMPLE, 1'b1, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MAX_SAMPLE, 1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MIN_SAMPLE, 1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  9'd1,   1'b0, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MAX_SAMPLE, 1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  9'd2,   1'b0, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MIN_SAMPLE, 1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  9'd1,   1'b0, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MAX_SAMPLE, 1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  9'd2,   1'b1, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MIN_SAMPLE, 1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  9'd1,   1'b0, 16'sd0,     1'b0, 1'b0, 17'sd0},
        '{ROW_ITEM, 9'd0,   1'b0, MAX_SAMPLE, 1'b0, 1'b0, 17'sd0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          i_record_start = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [OUT_BITS-1:0]    o_filtered;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index = CFG_WINDOW_LENGTH;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data = '0;

    // Predictor state: sample history, fill count, running sum and register copies.
    logic signed [SAMPLE_BITS-1:0] hist [MAX_WINDOW];
    logic [ADDR_BITS-1:0]          hist_ptr = '0;
    int unsigned                   hist_fill = 0;
    logic signed [SUM_BITS-1:0]    win_sum = '0;
    logic [CFG_DATA_BITS-1:0]      win_len_reg = 9'd1;
    logic                          mode_reg = 1'b0;
    logic signed [OUT_BITS-1:0]    filtered_q [$];

    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int phase_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_req_cnt = 0;
    int hold_ack_cnt = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    sliding_window_average_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_record_start (i_record_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_filtered     (o_filtered),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Computes the filtered value for one accepted item and advances the predictor state.
    function automatic logic signed [OUT_BITS-1:0] average_next(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic start
    );
        int eff;
        int avg;
        int res;
        logic [ADDR_BITS-1:0] old_idx;
        eff = (win_len_reg == 0) ? 1 :
              (win_len_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_len_reg);
        if (start) begin
            win_sum = '0;
            hist_fill = 0;
        end
        win_sum = win_sum + x;
        hist_fill++;
        // Only the entry one window back drops out, even when the count stays above it.
        if (hist_fill > eff) begin
            old_idx = hist_ptr - ADDR_BITS'(eff);
            win_sum = win_sum - hist[old_idx];
            hist_fill--;
        end
        hist[hist_ptr] = x;
        hist_ptr++;
        // Integer division in SystemVerilog truncates toward zero.
        avg = int'(win_sum) / int'(hist_fill);
        res = mode_reg ? int'(x) - avg : avg;
        if (res > OUT_LIMIT) begin
            res = OUT_LIMIT;
        end else if (res < -OUT_LIMIT) begin
            res = -OUT_LIMIT;
        end
        return OUT_BITS'(res);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0: return MAX_SAMPLE;
            1: return MIN_SAMPLE;
            2: return SAMPLE_BITS'(int'($urandom_range(64)) - 32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly short windows, with zero, the maximum and oversized values mixed in.
    function automatic logic [CFG_DATA_BITS-1:0] random_window();
        case ($urandom_range(15))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'd511;
            3: return CFG_DATA_BITS'($urandom_range(510, 257));
            4, 5: return CFG_DATA_BITS'($urandom_range(255, 17));
            default: return CFG_DATA_BITS'($urandom_range(16, 1));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_checked);
        error_count++;
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (filtered_q.size() != 0) @(negedge i_clk);
    endtask

    // Writes both registers on consecutive cycles; only called while the block is idle.
    task automatic set_config(input logic [CFG_DATA_BITS-1:0] win, input logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WINDOW_LENGTH;
        i_cfg_data  <= win;
        @(negedge i_clk);
        i_cfg_index <= CFG_FILTER_MODE;
        i_cfg_data  <= CFG_DATA_BITS'(mode);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        win_len_reg = win;
        mode_reg    = mode;
        phase_count++;
    endtask

    task automatic set_idle(input t_idle_style style);
        gap_pct   = (style == IDLE_SENDER) ? 66 : (style == IDLE_BOTH) ? 24 : 0;
        stall_pct <= (style == IDLE_RECEIVER) ? 66 : (style == IDLE_BOTH) ? 24 : 0;
    endtask

    // Offers one item after a random gap and records its expected result once accepted.
    task automatic send_sample(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic start,
        input logic typed,
        input logic signed [OUT_BITS-1:0] want
    );
        logic signed [OUT_BITS-1:0] predicted;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample       <= x;
        i_record_start <= start;
        do @(posedge i_clk); while (o_stall);
        predicted = average_next(x, start);
        filtered_q.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    // One random phase: new settings, then records of random samples.
    task automatic run_phase(
        input t_idle_style style,
        input int n,
        input bit with_hold,
        input bit with_pause
    );
        logic start;
        logic keep_record;
        drain_results();
        set_idle(style);
        keep_record = ($urandom_range(2) == 0);
        set_config(random_window(), 1'($urandom_range(1)));
        for (int k = 0; k < n; k++) begin
            start = (k == 0 && !keep_record) || ($urandom_range(39) == 0);
            if (with_hold && k == 2) hold_req_cnt <= hold_req_cnt + 1;
            if (with_pause && k == n / 2) drain_results();
            send_sample(random_sample(), start, 1'b0, '0);
        end
    endtask

    // Fills a full window, shrinks it to half and grows it back, so that the
    // running sum climbs past its range and wraps.
    task automatic run_sum_wrap();
        logic mode;
        drain_results();
        set_idle(IDLE_BOTH);
        mode = 1'($urandom_range(1));
        set_config(9'd256, mode);
        for (int k = 0; k < 256; k++) begin
            send_sample(k < 128 ? SAMPLE_BITS'(32767 - int'($urandom_range(3))) : MIN_SAMPLE,
                        k == 0, 1'b0, '0);
        end
        drain_results();
        set_config(9'd128, mode);
        for (int k = 0; k < 128; k++) begin
            send_sample(SAMPLE_BITS'(32767 - int'($urandom_range(3))), 1'b0, 1'b0, '0);
        end
        drain_results();
        set_config(9'd256, mode);
        for (int k = 0; k < 32; k++) begin
            send_sample(SAMPLE_BITS'(32767 - int'($urandom_range(3))), 1'b0, 1'b0, '0);
        end
    endtask

    // Output side: random stalls, or one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= LONG_HOLD;
            i_stall      <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("unexpected result", o_filtered, 0);
            end else begin
                if (o_filtered !== filtered_q[0]) begin
                    report_mismatch("filtered", o_filtered, filtered_q[0]);
                end
                void'(filtered_q.pop_front());
            end
            results_checked++;
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Watchdog: %0d cycles without any item moving, %0d results outstanding",
                     IDLE_LIMIT, filtered_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int p;
        int target;
        foreach (hist[j]) hist[j] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                drain_results();
                set_config(DIR_ROWS[r].win, DIR_ROWS[r].mode);
            end else begin
                send_sample(DIR_ROWS[r].smp, DIR_ROWS[r].start, DIR_ROWS[r].typed,
                            DIR_ROWS[r].want);
            end
        end

        // Random part: phases rotate through the idle styles.
        target = items_sent + NUM_RANDOM_ITEMS;
        p = 0;
        while (items_sent < target) begin
            if (p == 6) begin
                run_sum_wrap();
            end else if (p == 3) begin
                run_phase(IDLE_NONE, 40, 1'b1, 1'b0);
            end else begin
                run_phase(t_idle_style'(p % 4), $urandom_range(60, 15), 1'b0, p == 5);
            end
            p++;
        end

        drain_results();
        repeat (END_CYCLES) @(negedge i_clk);

        $display("Run covered %0d items over %0d register settings, %0d results compared.",
                 items_sent, phase_count, results_checked);
        $display("Included warm-up, window shrink in a record, sum wrap, output clamp, long stall.");
        if (error_count == 0 && filtered_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
